### rtl/core/led_effect_engine_defines.svh
// ----------------------------------------------------------------------------
// led_effect_engine_defines.svh
// Assertion macros shared by the LED effect engine checkers.
// ----------------------------------------------------------------------------
`ifndef LED_EFFECT_ENGINE_DEFINES_SVH
`define LED_EFFECT_ENGINE_DEFINES_SVH

// same-cycle implication
`define LEE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/led_eff_pkg.sv
// ----------------------------------------------------------------------------
// led_eff_pkg
// Types, widths and constants of the LED effect engine.
// ----------------------------------------------------------------------------
package led_eff_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;

  localparam int unsigned NOW_W      = 32;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned LEVEL_W    = 9;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL        = 9'd510;
  localparam logic [LEVEL_W-1:0] LEVEL_PULSE_START = 9'd100;

  localparam logic [STEP_W-1:0]     PULSE_STEP_RST     = 8'd3;
  localparam logic [INTERVAL_W-1:0] PULSE_INTERVAL_RST = 16'd15;
  localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST = 16'd400;

  typedef enum logic [MODE_W-1:0] {
    MODE_SOLID = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_BLINK = 2'd2
  } effect_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED            = 3'd0,
    REG_GREEN          = 3'd1,
    REG_BLUE           = 3'd2,
    REG_EFFECT_MODE    = 3'd3,
    REG_PULSE_STEP     = 3'd4,
    REG_PULSE_INTERVAL = 3'd5,
    REG_BLINK_INTERVAL = 3'd6
  } cfg_reg_t;

endpackage

### rtl/core/led_effect_engine.sv
// ----------------------------------------------------------------------------
// led_effect_engine
// Each accepted tick passes the input register and then the result register.
// Throughput: one tick per cycle; the input register and the result register
// each hold one word, and a held result stalls the input only if the next
// tick also yields a result. Synchronous active-low reset clears control
// state and loads register defaults; no result appears until a config write.
// ----------------------------------------------------------------------------
module led_effect_engine #(
  parameter int unsigned TIME_WIDTH = led_eff_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [led_eff_pkg::NOW_W-1:0]        in_now_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [led_eff_pkg::COLOR_W-1:0]      out_red,
  output logic [led_eff_pkg::COLOR_W-1:0]      out_green,
  output logic [led_eff_pkg::COLOR_W-1:0]      out_blue,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [led_eff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [led_eff_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned CW = led_eff_pkg::COLOR_W;
  localparam int unsigned LW = led_eff_pkg::LEVEL_W;
  localparam int unsigned NW = led_eff_pkg::NOW_W;

  // configuration registers
  logic [CW-1:0]                        red_r, red_nxt;
  logic [CW-1:0]                        green_r, green_nxt;
  logic [CW-1:0]                        blue_r, blue_nxt;
  logic [led_eff_pkg::MODE_W-1:0]       mode_r, mode_nxt;
  logic [led_eff_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [led_eff_pkg::INTERVAL_W-1:0]   pulse_int_r, pulse_int_nxt;
  logic [led_eff_pkg::INTERVAL_W-1:0]   blink_int_r, blink_int_nxt;

  // animation state
  logic [LW-1:0]         bright_r, bright_nxt;
  logic                  rising_r, rising_nxt;
  logic                  blink_lit_r, blink_lit_nxt;
  logic                  solid_pend_r, solid_pend_nxt;
  logic [TIME_WIDTH-1:0] last_pulse_r, last_pulse_nxt;
  logic [TIME_WIDTH-1:0] last_blink_r, last_blink_nxt;

  // input stage
  logic                  s1_valid_r, s1_valid_nxt;
  logic [TIME_WIDTH-1:0] s1_time_r;
  logic [TIME_WIDTH+NW-1:0] now_ext;

  // result stage
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_red_r, out_green_r, out_blue_r;
  logic [CW-1:0] res_red, res_green, res_blue;
  logic [CW-1:0] scl_red, scl_green, scl_blue;

  logic          in_acc, out_free, s1_adv, res_emit;
  logic          cfg_hit;
  logic [led_eff_pkg::MODE_W-1:0] mode_new;

  logic [TIME_WIDTH-1:0] pulse_elapsed, blink_elapsed;
  logic                  pulse_due, blink_due;
  logic [LW:0]           ramp_sum;
  logic [LW-1:0]         bright_step;
  logic                  rising_step;

  assign now_ext   = {{TIME_WIDTH{1'b0}}, in_now_ms};
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && (out_free || !res_emit);
  assign in_stall  = s1_valid_r && !s1_adv;

  assign pulse_elapsed = s1_time_r - last_pulse_r;
  assign blink_elapsed = s1_time_r - last_blink_r;
  assign pulse_due     = pulse_elapsed >= TIME_WIDTH'(pulse_int_r);
  assign blink_due     = blink_elapsed >= TIME_WIDTH'(blink_int_r);

  // brightness ramp: saturate and reverse at both ends
  always_comb begin
    ramp_sum    = {1'b0, bright_r} + (LW+1)'(step_r);
    bright_step = bright_r;
    rising_step = rising_r;
    if (rising_r) begin
      if (ramp_sum >= (LW+1)'(led_eff_pkg::LEVEL_FULL)) begin
        bright_step = led_eff_pkg::LEVEL_FULL;
        rising_step = 1'b0;
      end else begin
        bright_step = ramp_sum[LW-1:0];
      end
    end else begin
      if (bright_r <= LW'(step_r)) begin
        bright_step = '0;
        rising_step = 1'b1;
      end else begin
        bright_step = bright_r - LW'(step_r);
      end
    end
  end

  led_eff_scale u_scale_red (.color(red_r), .level(bright_step), .scaled(scl_red));
  led_eff_scale u_scale_green (.color(green_r), .level(bright_step), .scaled(scl_green));
  led_eff_scale u_scale_blue (.color(blue_r), .level(bright_step), .scaled(scl_blue));

  always_comb begin
    unique case (led_eff_pkg::effect_mode_t'(mode_r))
      led_eff_pkg::MODE_SOLID: res_emit = solid_pend_r;
      led_eff_pkg::MODE_PULSE: res_emit = pulse_due;
      led_eff_pkg::MODE_BLINK: res_emit = blink_due;
      default:                 res_emit = 1'b0;
    endcase
  end

  // per-tick effect decision
  always_comb begin
    res_red        = '0;
    res_green      = '0;
    res_blue       = '0;
    bright_nxt     = bright_r;
    rising_nxt     = rising_r;
    blink_lit_nxt  = blink_lit_r;
    solid_pend_nxt = solid_pend_r;
    last_pulse_nxt = last_pulse_r;
    last_blink_nxt = last_blink_r;
    unique case (led_eff_pkg::effect_mode_t'(mode_r))
      led_eff_pkg::MODE_SOLID: begin
        res_red   = red_r;
        res_green = green_r;
        res_blue  = blue_r;
        if (s1_adv) begin
          solid_pend_nxt = 1'b0;
        end
      end
      led_eff_pkg::MODE_PULSE: begin
        res_red   = scl_red;
        res_green = scl_green;
        res_blue  = scl_blue;
        if (s1_adv && pulse_due) begin
          last_pulse_nxt = s1_time_r;
          bright_nxt     = bright_step;
          rising_nxt     = rising_step;
        end
      end
      led_eff_pkg::MODE_BLINK: begin
        if (!blink_lit_r) begin
          res_red   = red_r;
          res_green = green_r;
          res_blue  = blue_r;
        end
        if (s1_adv && blink_due) begin
          last_blink_nxt = s1_time_r;
          blink_lit_nxt  = !blink_lit_r;
        end
      end
      default: ;
    endcase

    // register write
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    mode_nxt      = mode_r;
    step_nxt      = step_r;
    pulse_int_nxt = pulse_int_r;
    blink_int_nxt = blink_int_r;
    cfg_hit       = 1'b0;
    if (cfg_valid) begin
      cfg_hit = 1'b1;
      unique case (led_eff_pkg::cfg_reg_t'(cfg_index))
        led_eff_pkg::REG_RED:            red_nxt       = cfg_data[CW-1:0];
        led_eff_pkg::REG_GREEN:          green_nxt     = cfg_data[CW-1:0];
        led_eff_pkg::REG_BLUE:           blue_nxt      = cfg_data[CW-1:0];
        led_eff_pkg::REG_EFFECT_MODE:    mode_nxt      = cfg_data[led_eff_pkg::MODE_W-1:0];
        led_eff_pkg::REG_PULSE_STEP:     step_nxt      = cfg_data[led_eff_pkg::STEP_W-1:0];
        led_eff_pkg::REG_PULSE_INTERVAL: pulse_int_nxt = cfg_data;
        led_eff_pkg::REG_BLINK_INTERVAL: blink_int_nxt = cfg_data;
        default:                         cfg_hit       = 1'b0;
      endcase
    end
    mode_new = mode_nxt;

    // restart the animation on any write to a defined register
    if (cfg_hit) begin
      bright_nxt     = (mode_new == led_eff_pkg::MODE_PULSE) ?
                       led_eff_pkg::LEVEL_PULSE_START : '0;
      rising_nxt     = 1'b1;
      blink_lit_nxt  = 1'b0;
      solid_pend_nxt = (mode_new == led_eff_pkg::MODE_SOLID);
    end
  end

  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = (s1_adv && res_emit) || (out_valid_r && !out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r        <= '0;
      green_r      <= '0;
      blue_r       <= '0;
      mode_r       <= led_eff_pkg::MODE_SOLID;
      step_r       <= led_eff_pkg::PULSE_STEP_RST;
      pulse_int_r  <= led_eff_pkg::PULSE_INTERVAL_RST;
      blink_int_r  <= led_eff_pkg::BLINK_INTERVAL_RST;
      bright_r     <= '0;
      rising_r     <= 1'b1;
      blink_lit_r  <= 1'b0;
      solid_pend_r <= 1'b0;
      last_pulse_r <= '0;
      last_blink_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      red_r        <= red_nxt;
      green_r      <= green_nxt;
      blue_r       <= blue_nxt;
      mode_r       <= mode_nxt;
      step_r       <= step_nxt;
      pulse_int_r  <= pulse_int_nxt;
      blink_int_r  <= blink_int_nxt;
      bright_r     <= bright_nxt;
      rising_r     <= rising_nxt;
      blink_lit_r  <= blink_lit_nxt;
      solid_pend_r <= solid_pend_nxt;
      last_pulse_r <= last_pulse_nxt;
      last_blink_r <= last_blink_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_time_r <= now_ext[TIME_WIDTH-1:0];
    end
    if (s1_adv && res_emit) begin
      out_red_r   <= res_red;
      out_green_r <= res_green;
      out_blue_r  <= res_blue;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

### rtl/core/led_eff_scale.sv
// ----------------------------------------------------------------------------
// led_eff_scale
// One color channel scaled by a half-unit level: floor(color * level / 510).
// ----------------------------------------------------------------------------
module led_eff_scale (
  input  logic [led_eff_pkg::COLOR_W-1:0] color,
  input  logic [led_eff_pkg::LEVEL_W-1:0] level,
  output logic [led_eff_pkg::COLOR_W-1:0] scaled
);

  logic [16:0] prod;
  logic [15:0] half;
  logic [16:0] quot_sum;

  // floor(p/510) = floor(floor(p/2)/255); divide by 255 via add and shift
  assign prod     = 17'(color) * 17'(level);
  assign half     = prod[16:1];
  assign quot_sum = {1'b0, half} + 17'd1 + {9'd0, half[15:8]};
  assign scaled   = quot_sum[15:8];

endmodule

### rtl/core/led_eff_checker.sv
// ----------------------------------------------------------------------------
// led_eff_checker
// Port-level checks of the LED effect engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_effect_engine_defines.svh"

module led_eff_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [led_eff_pkg::COLOR_W-1:0] out_red,
  input logic [led_eff_pkg::COLOR_W-1:0] out_green,
  input logic [led_eff_pkg::COLOR_W-1:0] out_blue
);

  `LEE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled result word changed")

  `LEE_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled while result path free")

  `LEE_ASSERT_NOW(a_rise_src, $rose(out_valid), $past(in_valid && !in_stall, 2), "result word without an accepted tick two cycles earlier")

endmodule

bind led_effect_engine led_eff_checker u_led_eff_checker (.*);

### tb/led_effect_engine_test.sv
// ----------------------------------------------------------------------------
// led_effect_engine_test
// Self-checking bench for the LED effect engine. A directed table walks the
// solid, pulse and blink effects, the unused mode, ignored register index,
// zero step, zero and maximum intervals, and time wrap. Random phases follow
// with random settings and tick times under varying sender and receiver
// pacing. Each result word must match the in-bench predictor or a typed value.
// ----------------------------------------------------------------------------
module led_effect_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import led_eff_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned TICK_TARGET   = 600;
  localparam int unsigned PRINT_CAP     = 200;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RGB} chk_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [NOW_W-1:0]      now;
    chk_kind_t             chk;
    rgb_t                  rgb;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [NOW_W-1:0]      in_now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  rgb_t      rgb_due[$];
  plan_row_t plan[$];

  // effect predictor state
  logic [COLOR_W-1:0]    red_q, green_q, blue_q;
  logic [MODE_W-1:0]     mode_q;
  logic [STEP_W-1:0]     step_q;
  logic [INTERVAL_W-1:0] pulse_gap_q, blink_gap_q;
  logic [LEVEL_W-1:0]    level_q;
  logic                  rising_q, lit_q, solid_due_q;
  logic [NOW_W-1:0]      last_pulse_q, last_blink_q;

  led_effect_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_now_ms (in_now_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_effect_engine regression: fail");
      $finish;
    end
  end

  function automatic void reset_effect();
    red_q        = '0;
    green_q      = '0;
    blue_q       = '0;
    mode_q       = MODE_SOLID;
    step_q       = PULSE_STEP_RST;
    pulse_gap_q  = PULSE_INTERVAL_RST;
    blink_gap_q  = BLINK_INTERVAL_RST;
    level_q      = '0;
    rising_q     = 1'b1;
    lit_q        = 1'b0;
    solid_due_q  = 1'b0;
    last_pulse_q = '0;
    last_blink_q = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_RED:            red_q = data[COLOR_W-1:0];
      REG_GREEN:          green_q = data[COLOR_W-1:0];
      REG_BLUE:           blue_q = data[COLOR_W-1:0];
      REG_EFFECT_MODE:    mode_q = data[MODE_W-1:0];
      REG_PULSE_STEP:     step_q = data[STEP_W-1:0];
      REG_PULSE_INTERVAL: pulse_gap_q = data;
      REG_BLINK_INTERVAL: blink_gap_q = data;
      default:            return;
    endcase
    level_q     = (mode_q == MODE_PULSE) ? LEVEL_PULSE_START : '0;
    rising_q    = 1'b1;
    lit_q       = 1'b0;
    solid_due_q = (mode_q == MODE_SOLID);
  endfunction

  function automatic logic [COLOR_W-1:0] dim(input logic [COLOR_W-1:0] c,
                                             input logic [LEVEL_W-1:0] lvl);
    int unsigned prod;
    prod = c;
    prod = prod * lvl;
    return 8'(prod / LEVEL_FULL);
  endfunction

  function automatic bit advance_effect(input logic [NOW_W-1:0] t, output rgb_t word);
    logic [NOW_W-1:0] gap;
    logic [LEVEL_W:0] raised;
    word = '0;
    case (mode_q)
      MODE_SOLID: begin
        if (!solid_due_q) return 1'b0;
        solid_due_q = 1'b0;
        word = '{red_q, green_q, blue_q};
        return 1'b1;
      end
      MODE_PULSE: begin
        gap = t - last_pulse_q;
        if (gap < {16'd0, pulse_gap_q}) return 1'b0;
        last_pulse_q = t;
        if (rising_q) begin
          raised = level_q + step_q;
          if (raised >= LEVEL_FULL) begin
            level_q  = LEVEL_FULL;
            rising_q = 1'b0;
          end else begin
            level_q = raised[LEVEL_W-1:0];
          end
        end else if (level_q <= step_q) begin
          level_q  = '0;
          rising_q = 1'b1;
        end else begin
          level_q = level_q - step_q;
        end
        word = '{dim(red_q, level_q), dim(green_q, level_q), dim(blue_q, level_q)};
        return 1'b1;
      end
      MODE_BLINK: begin
        gap = t - last_blink_q;
        if (gap < {16'd0, blink_gap_q}) return 1'b0;
        last_blink_q = t;
        lit_q = !lit_q;
        if (lit_q) word = '{red_q, green_q, blue_q};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_word();
    rgb_t want;
    if (rgb_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected word %0d/%0d/%0d", out_red, out_green, out_blue));
      return;
    end
    want = rgb_due.pop_front();
    if (out_red !== want.red)
      flag_mismatch($sformatf("red %0d, want %0d", out_red, want.red));
    if (out_green !== want.green)
      flag_mismatch($sformatf("green %0d, want %0d", out_green, want.green));
    if (out_blue !== want.blue)
      flag_mismatch($sformatf("blue %0d, want %0d", out_blue, want.blue));
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) check_word();
  end

  task automatic set_pace(input int unsigned sel);
    case (sel % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 69; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 69; end
      default: begin in_idle_pct = 11; out_stall_pct = 11; end
    endcase
  endtask

  task automatic send_tick(input logic [NOW_W-1:0] t, input chk_kind_t chk,
                           input rgb_t typed, output bit produced);
    rgb_t word;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_now_ms <= t;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    produced = advance_effect(t, word);
    case (chk)
      CHK_MODEL: if (produced) rgb_due.push_back(word);
      CHK_RGB:   rgb_due.push_back(typed);
      default:   ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the input until every expected word is out and the pipe is empty
  task automatic wait_led_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void put_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{ROW_CFG, idx, data, '0, CHK_NONE, '0};
    plan.push_back(row);
  endfunction

  function automatic void put_tick(input logic [NOW_W-1:0] t, input chk_kind_t chk);
    plan_row_t row;
    row = '{ROW_TICK, '0, '0, t, chk, '0};
    plan.push_back(row);
  endfunction

  function automatic void put_seen(input logic [NOW_W-1:0] t, input logic [7:0] r,
                                   input logic [7:0] g, input logic [7:0] b);
    plan_row_t row;
    row = '{ROW_TICK, '0, '0, t, CHK_RGB, '{r, g, b}};
    plan.push_back(row);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_color();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return {8'($urandom()), 8'd0};
    if (r < 20) return {8'($urandom()), 8'd255};
    return 16'($urandom());
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_step();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return {8'($urandom()), 8'd0};
    if (r < 10) return {8'($urandom()), 8'd255};
    return {8'($urandom()), 8'($urandom_range(40, 1))};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_interval();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 15) return 16'hFFFF;
    if (r < 25) return 16'($urandom());
    return 16'($urandom_range(30, 1));
  endfunction

  task automatic pick_effect(output logic [MODE_W-1:0] mode);
    int unsigned r;
    r = $urandom_range(99);
    mode = (r < 12) ? MODE_SOLID : (r < 52) ? MODE_PULSE :
           (r < 94) ? MODE_BLINK : MODE_UNUSED;
    if ($urandom_range(1)) write_reg(REG_RED, rand_color());
    if ($urandom_range(1)) write_reg(REG_GREEN, rand_color());
    if ($urandom_range(1)) write_reg(REG_BLUE, rand_color());
    if ($urandom_range(1)) write_reg(REG_PULSE_STEP, rand_step());
    if ($urandom_range(1)) write_reg(REG_PULSE_INTERVAL, rand_interval());
    if ($urandom_range(1)) write_reg(REG_BLINK_INTERVAL, rand_interval());
    if ($urandom_range(9) == 0) write_reg(REG_NONE, 16'($urandom()));
    write_reg(REG_EFFECT_MODE, {14'($urandom()), mode});
  endtask

  initial begin
    logic [NOW_W-1:0]  clock_ms;
    logic [MODE_W-1:0] mode;
    int unsigned       counted, phase, n_ticks, span, r, waited;
    bit                hit;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_now_ms <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    reset_effect();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_tick(32'd0, CHK_NONE);
    put_tick(32'hFFFF_FFFF, CHK_NONE);
    put_cfg(REG_RED, 16'h00FF);
    put_cfg(REG_GREEN, 16'hFF00);
    put_cfg(REG_BLUE, 16'h0080);
    put_seen(32'd5, 8'd255, 8'd0, 8'd128);
    put_tick(32'd6, CHK_NONE);
    put_cfg(REG_NONE, 16'hFFFF);
    put_tick(32'd7, CHK_NONE);
    put_cfg(REG_EFFECT_MODE, {14'd0, MODE_UNUSED});
    put_tick(32'hAAAA_5555, CHK_NONE);
    put_cfg(REG_EFFECT_MODE, {14'd0, MODE_PULSE});
    put_tick(32'd14, CHK_NONE);
    put_tick(32'd15, CHK_MODEL);
    put_cfg(REG_PULSE_STEP, 16'hFFFF);
    put_tick(32'd30, CHK_MODEL);
    put_seen(32'd45, 8'd255, 8'd0, 8'd128);
    put_tick(32'd60, CHK_MODEL);
    put_seen(32'd75, 8'd0, 8'd0, 8'd0);
    put_cfg(REG_PULSE_STEP, 16'h0000);
    put_tick(32'd90, CHK_MODEL);
    put_cfg(REG_PULSE_INTERVAL, 16'h0000);
    put_tick(32'd90, CHK_MODEL);
    put_tick(32'd90, CHK_MODEL);
    put_cfg(REG_PULSE_INTERVAL, 16'hFFFF);
    put_tick(32'd65624, CHK_NONE);
    put_tick(32'hFFFF_FFF0, CHK_MODEL);
    put_tick(32'h0000_FFEF, CHK_MODEL);
    put_cfg(REG_EFFECT_MODE, {14'd0, MODE_BLINK});
    put_tick(32'd399, CHK_NONE);
    put_seen(32'd400, 8'd255, 8'd0, 8'd128);
    put_seen(32'd800, 8'd0, 8'd0, 8'd0);
    put_cfg(REG_BLINK_INTERVAL, 16'h0000);
    put_seen(32'd800, 8'd255, 8'd0, 8'd128);
    put_seen(32'd800, 8'd0, 8'd0, 8'd0);
    put_cfg(REG_RED, 16'h0000);
    put_cfg(REG_GREEN, 16'h00FF);
    put_cfg(REG_BLUE, 16'h00FF);
    put_cfg(REG_EFFECT_MODE, {14'd0, MODE_SOLID});
    put_seen(32'd801, 8'd0, 8'd255, 8'd255);

    set_pace(0);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_led_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].now, plan[i].chk, plan[i].rgb, hit);
      end
    end

    clock_ms = 32'd801;
    counted  = 0;
    phase    = 0;
    while (counted < TICK_TARGET) begin
      wait_led_idle();
      set_pace(phase);
      pick_effect(mode);
      span = (mode == MODE_PULSE) ? pulse_gap_q : blink_gap_q;
      n_ticks = (mode == MODE_SOLID) ? 4 : (mode == MODE_UNUSED) ? 3 :
                $urandom_range(50, 20);
      repeat (n_ticks) begin
        r = $urandom_range(99);
        if (r < 4)      clock_ms = $urandom();
        else if (r < 6) clock_ms = 32'hFFFF_FFFF - $urandom_range(2 * span + 2);
        else            clock_ms = clock_ms + $urandom_range(2 * span + 2);
        send_tick(clock_ms, CHK_MODEL, '0, hit);
        if (hit || mode == MODE_PULSE || mode == MODE_BLINK) counted++;
        if ($urandom_range(99) < 3) wait_led_idle();
      end
      phase++;
    end

    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (rgb_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (rgb_due.size() != 0)
      flag_mismatch($sformatf("%0d expected words never arrived", rgb_due.size()));

    if (mismatches == 0) begin
      $display("led_effect_engine regression: pass");
    end else begin
      $display("led_effect_engine regression: fail");
    end
    $finish;
  end

endmodule

### led_effect_engine.f
+incdir+rtl/core
rtl/core/led_eff_pkg.sv
rtl/core/led_eff_scale.sv
rtl/core/led_effect_engine.sv
rtl/core/led_eff_checker.sv
tb/led_effect_engine_test.sv
